@@ rtl/sps_pkg.sv @@
// shared types and constants for the sandpile sweep core
`default_nettype none
package sps_pkg;

  localparam int CELL_W   = 16;
  localparam int THRESH_W = 8;
  localparam int MARGIN_W = 7;
  localparam int COORD_W  = 6;

  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_SWEEP  = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_MARGIN = 2'd3;

  localparam logic [CELL_W-1:0] CELL_MAX = '1;
  localparam int MARGIN_MAX = 127;

  // what a full-grid read scan collects
  typedef enum logic [1:0] {
    KIND_ALERT,
    KIND_STAB,
    KIND_MARG
  } scan_kind_t;

  typedef struct packed {
    logic       clr_go;    // write zero at cursor, advance
    logic       scan_go;   // read at cursor, advance
    scan_kind_t kind;
    logic       load;      // capture item fields, clear flags
    logic       wr_user;
    logic       rd_user;
    logic       rd_cur;
    logic       wr_cur;    // write cell minus threshold
    logic       adv;       // advance cursor
    logic       nb_clr;
    logic       nb_rd;
    logic       nb_wr;     // saturating increment of neighbor
    logic       nb_skip;   // neighbor off grid
    logic       out_load;
  } sps_cmd_t;

  typedef struct packed {
    logic       last;      // cursor on final cell
    logic       hot;       // read data at or above threshold
    logic       nb_off;
    logic       nb_last;
    logic [1:0] mode;
  } sps_stat_t;

  function automatic logic [MARGIN_W-1:0] sat7(input int unsigned n);
    return (n > MARGIN_MAX) ? MARGIN_W'(MARGIN_MAX) : MARGIN_W'(n);
  endfunction

endpackage
`default_nettype wire

@@ rtl/sps_ram.sv @@
// generic single write, single read ram with registered read data
`default_nettype none
module sps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // storage write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/sps_ctrl.sv @@
// sequencer for clear, scans, sweep read-modify-write and result handoff
`default_nettype none
module sps_ctrl import sps_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire sps_stat_t st,
  output sps_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WR,
    S_RD,
    S_RDW,
    S_SCAN,
    S_DRAIN,
    S_SW_RD,
    S_SW_CHK,
    S_NB_RD,
    S_NB_WR,
    S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  scan_kind_t kind_r, kind_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.kind      = kind_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_go = 1'b1;
        if (st.last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (st.mode)
            MODE_WRITE: state_nxt = S_WR;
            MODE_READ:  state_nxt = S_RD;
            MODE_SWEEP: begin
              state_nxt = S_SCAN;
              kind_nxt  = KIND_ALERT;
            end
            default: begin
              state_nxt = S_SCAN;
              kind_nxt  = KIND_MARG;
            end
          endcase
        end
      end
      S_WR: begin
        cmd.wr_user = 1'b1;
        state_nxt   = S_DONE;
      end
      S_RD: begin
        cmd.rd_user = 1'b1;
        state_nxt   = S_RDW;
      end
      S_RDW: state_nxt = S_DONE;
      S_SCAN: begin
        cmd.scan_go = 1'b1;
        if (st.last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = (kind_r == KIND_ALERT) ? S_SW_RD : S_DONE;
      end
      S_SW_RD: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = S_SW_CHK;
      end
      S_SW_CHK: begin
        if (st.hot) begin
          cmd.wr_cur = 1'b1;
          cmd.nb_clr = 1'b1;
          state_nxt  = S_NB_RD;
        end else begin
          cmd.adv = 1'b1;
          if (st.last) begin
            state_nxt = S_SCAN;
            kind_nxt  = KIND_STAB;
          end else begin
            state_nxt = S_SW_RD;
          end
        end
      end
      S_NB_RD: begin
        if (st.nb_off) begin
          cmd.nb_skip = 1'b1;
          if (st.nb_last) begin
            cmd.adv = 1'b1;
            if (st.last) begin
              state_nxt = S_SCAN;
              kind_nxt  = KIND_STAB;
            end else begin
              state_nxt = S_SW_RD;
            end
          end
        end else begin
          cmd.nb_rd = 1'b1;
          state_nxt = S_NB_WR;
        end
      end
      S_NB_WR: begin
        cmd.nb_wr = 1'b1;
        if (st.nb_last) begin
          cmd.adv = 1'b1;
          if (st.last) begin
            state_nxt = S_SCAN;
            kind_nxt  = KIND_STAB;
          end else begin
            state_nxt = S_SW_RD;
          end
        end else begin
          state_nxt = S_NB_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      kind_r      <= KIND_ALERT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a transfer in starts work, so the port closes right after
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous item in flight");

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // every neighbor write follows its read
  a_nb_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_NB_WR |-> $past(state_r) == S_NB_RD)
    else $error("neighbor write without read");

endmodule
`default_nettype wire

@@ rtl/sps_dp.sv @@
// grid storage, cursor, neighbor addressing, scan flags and result registers
`default_nettype none
module sps_dp import sps_pkg::*; #(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sps_cmd_t             cmd,
  output sps_stat_t                 st,
  input  wire logic [THRESH_W-1:0]  thresh,
  input  wire logic [1:0]           in_mode,
  input  wire logic [COORD_W-1:0]   in_row,
  input  wire logic [COORD_W-1:0]   in_col,
  input  wire logic [CELL_W-1:0]    in_value,
  output logic      [CELL_W-1:0]    out_cell_value,
  output logic                      out_stable,
  output logic                      out_edge_alert,
  output logic                      out_spilled,
  output logic      [MARGIN_W-1:0]  out_top_empty,
  output logic      [MARGIN_W-1:0]  out_bottom_empty,
  output logic      [MARGIN_W-1:0]  out_left_empty,
  output logic      [MARGIN_W-1:0]  out_right_empty
);

  localparam int DEPTH = GRID_ROWS * GRID_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLS);
  localparam logic [RW-1:0] ROW_LAST = RW'(GRID_ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(GRID_COLS - 1);

  // cursor and item registers
  logic [RW-1:0]       r_r, p_row_r;
  logic [CW-1:0]       c_r, p_col_r;
  logic [1:0]          nb_r;
  logic                rd_vld_r;
  logic [1:0]          mode_r;
  logic [COORD_W-1:0]  urow_r, ucol_r;
  logic [CELL_W-1:0]   uval_r;
  logic                alert_r, spill_r, unstable_r, found_r;
  logic [RW-1:0]       min_row_r, max_row_r;
  logic [CW-1:0]       min_col_r, max_col_r;

  logic [CELL_W-1:0]   rdata;
  logic                we, re;
  logic [AW-1:0]       waddr, raddr;
  logic [CELL_W-1:0]   wdata;

  logic [31:0]         cur_lin, nb_lin, usr_lin;
  logic [RW-1:0]       nr;
  logic [CW-1:0]       nc;
  logic                nb_off;
  logic                user_in;
  logic                hot, near, border, nz;

  // linear addresses
  assign cur_lin = 32'(r_r) * 32'(GRID_COLS) + 32'(c_r);
  assign nb_lin  = 32'(nr) * 32'(GRID_COLS) + 32'(nc);
  assign usr_lin = 32'(urow_r) * 32'(GRID_COLS) + 32'(ucol_r);
  assign user_in = (32'(urow_r) < 32'(GRID_ROWS)) && (32'(ucol_r) < 32'(GRID_COLS));

  // neighbor position: down, up, right, left
  always_comb begin
    nr     = r_r;
    nc     = c_r;
    nb_off = 1'b0;
    unique case (nb_r)
      2'd0: begin
        nr     = r_r + RW'(1);
        nb_off = (r_r == ROW_LAST);
      end
      2'd1: begin
        nr     = r_r - RW'(1);
        nb_off = (r_r == '0);
      end
      2'd2: begin
        nc     = c_r + CW'(1);
        nb_off = (c_r == COL_LAST);
      end
      default: begin
        nc     = c_r - CW'(1);
        nb_off = (c_r == '0);
      end
    endcase
  end

  assign hot        = ({8'd0, rdata} >= {{CELL_W{1'b0}}, thresh});
  assign near       = ({1'b0, rdata} + 17'd1 >= {9'd0, thresh});
  assign nz         = (rdata != '0);
  assign border     = (p_row_r == '0) || (p_row_r == ROW_LAST) ||
                      (p_col_r == '0) || (p_col_r == COL_LAST);
  assign st.hot     = hot;
  assign st.last    = (r_r == ROW_LAST) && (c_r == COL_LAST);
  assign st.nb_off  = nb_off;
  assign st.nb_last = (nb_r == 2'd3);
  assign st.mode    = in_mode;

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = cur_lin[AW-1:0];
    wdata = '0;
    if (cmd.clr_go) begin
      we = 1'b1;
    end else if (cmd.wr_user) begin
      we    = user_in;
      waddr = usr_lin[AW-1:0];
      wdata = uval_r;
    end else if (cmd.wr_cur) begin
      we    = 1'b1;
      wdata = rdata - CELL_W'(thresh);
    end else if (cmd.nb_wr) begin
      we    = 1'b1;
      waddr = nb_lin[AW-1:0];
      wdata = (rdata == CELL_MAX) ? rdata : rdata + CELL_W'(1);
    end
  end

  always_comb begin
    re    = cmd.scan_go || cmd.rd_cur || cmd.nb_rd || (cmd.rd_user && user_in);
    raddr = cur_lin[AW-1:0];
    if (cmd.rd_user) raddr = usr_lin[AW-1:0];
    else if (cmd.nb_rd) raddr = nb_lin[AW-1:0];
  end

  sps_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_grid (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // cursor, neighbor index and scan pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_r      <= '0;
      c_r      <= '0;
      nb_r     <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_go;
      if (cmd.clr_go || cmd.scan_go || cmd.adv) begin
        if (c_r == COL_LAST) begin
          c_r <= '0;
          r_r <= (r_r == ROW_LAST) ? '0 : r_r + RW'(1);
        end else begin
          c_r <= c_r + CW'(1);
        end
      end
      if (cmd.nb_clr) nb_r <= '0;
      else if (cmd.nb_skip || cmd.nb_wr) nb_r <= nb_r + 2'd1;
    end
  end

  // item fields and scan flags
  always_ff @(posedge clk) begin
    p_row_r <= r_r;
    p_col_r <= c_r;
    if (cmd.load) begin
      mode_r     <= in_mode;
      urow_r     <= in_row;
      ucol_r     <= in_col;
      uval_r     <= in_value;
      alert_r    <= 1'b0;
      spill_r    <= 1'b0;
      unstable_r <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      if (cmd.nb_skip) spill_r <= 1'b1;
      if (rd_vld_r) begin
        unique case (cmd.kind)
          KIND_ALERT: if (border && near) alert_r <= 1'b1;
          KIND_STAB:  if (hot) unstable_r <= 1'b1;
          default: begin
            if (nz) begin
              found_r   <= 1'b1;
              max_row_r <= p_row_r;
              if (!found_r) min_row_r <= p_row_r;
              if (!found_r || p_col_r < min_col_r) min_col_r <= p_col_r;
              if (!found_r || p_col_r > max_col_r) max_col_r <= p_col_r;
            end
          end
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cell_value   <= (mode_r == MODE_READ && user_in) ? rdata : '0;
      out_stable       <= (mode_r == MODE_SWEEP) && !unstable_r;
      out_edge_alert   <= (mode_r == MODE_SWEEP) && alert_r;
      out_spilled      <= (mode_r == MODE_SWEEP) && spill_r;
      if (mode_r == MODE_MARGIN) begin
        out_top_empty    <= found_r ? sat7(32'(min_row_r)) : sat7(GRID_ROWS);
        out_bottom_empty <= found_r ? sat7(32'(ROW_LAST - max_row_r)) : sat7(GRID_ROWS);
        out_left_empty   <= found_r ? sat7(32'(min_col_r)) : sat7(GRID_COLS);
        out_right_empty  <= found_r ? sat7(32'(COL_LAST - max_col_r)) : sat7(GRID_COLS);
      end else begin
        out_top_empty    <= '0;
        out_bottom_empty <= '0;
        out_left_empty   <= '0;
        out_right_empty  <= '0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/sandpile_topple_sweep_core.sv @@
// top level of the sandpile sweep core: config register, sequencer, datapath
`default_nettype none
// Holds a GRID_ROWS x GRID_COLS grid of 16-bit grain counts in one ram
// (one write, one registered read per cycle). After reset the core zeroes
// the grid, one cell per cycle, with in_ready low. A cell write goes through
// a write state and a done state; a cell read through a read state, a wait
// state for the registered ram data and a done state. A margin query scans
// every cell once. A sweep runs a border check scan, then visits every cell
// with a read-modify-write (a read, then a check that writes back a toppling
// cell and reads and increments each of its four neighbors on the grid),
// then a stability scan. One item is worked on at a time; the result
// register lets the next item be taken while a result waits.
module sandpile_topple_sweep_core import sps_pkg::*; #(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_mode,
  input  wire logic [COORD_W-1:0]  in_row,
  input  wire logic [COORD_W-1:0]  in_col,
  input  wire logic [CELL_W-1:0]   in_value,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [CELL_W-1:0]   out_cell_value,
  output logic                     out_stable,
  output logic                     out_edge_alert,
  output logic                     out_spilled,
  output logic      [MARGIN_W-1:0] out_top_empty,
  output logic      [MARGIN_W-1:0] out_bottom_empty,
  output logic      [MARGIN_W-1:0] out_left_empty,
  output logic      [MARGIN_W-1:0] out_right_empty,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [2:0]          cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic      [31:0]         cfg_prdata,
  output logic                     cfg_pready
);

  localparam logic REG_THRESH = 1'b0;

  logic [THRESH_W-1:0] thresh_r;
  sps_cmd_t            cmd;
  sps_stat_t           st;

  // threshold register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_THRESH) ? {24'd0, thresh_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= 8'd4;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_THRESH) begin
      thresh_r <= cfg_pwdata[THRESH_W-1:0];
    end
  end

  sps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  sps_dp #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .thresh           (thresh_r),
    .in_mode          (in_mode),
    .in_row           (in_row),
    .in_col           (in_col),
    .in_value         (in_value),
    .out_cell_value   (out_cell_value),
    .out_stable       (out_stable),
    .out_edge_alert   (out_edge_alert),
    .out_spilled      (out_spilled),
    .out_top_empty    (out_top_empty),
    .out_bottom_empty (out_bottom_empty),
    .out_left_empty   (out_left_empty),
    .out_right_empty  (out_right_empty)
  );

endmodule
`default_nettype wire
